/* rtl/rafd_pkg.sv */
// ---------------------------------------------------------------------------
// rafd_pkg
// Shared types, codes and helper functions for the accessory frame decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package rafd_pkg;

   localparam int FRAME_BITS = 18;
   localparam int COUNT_W    = 5;
   localparam int ADDR_W     = 8;
   localparam int FUNC_W     = 2;
   localparam int DATA_W     = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   localparam logic [7:0] SHORT_LIMIT_RST = 8'd40;
   localparam logic [7:0] LONG_LOW_RST    = 8'd70;
   localparam logic [7:0] LONG_HIGH_RST   = 8'd130;

   // Line event codes
   typedef enum logic [1:0] {
      MODE_EDGE  = 2'd0,
      MODE_GAP   = 2'd1,
      MODE_HOLD  = 2'd2,
      MODE_SPARE = 2'd3
   } mode_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SHORT_LIMIT    = 3'd0,
      CSR_LONG_LOW       = 3'd1,
      CSR_LONG_HIGH      = 3'd2,
      CSR_SWITCH_ADDRESS = 3'd3,
      CSR_SWITCH_DATA    = 3'd4
   } csr_index_type;

   // Decoded configuration seen by the frame engine
   typedef struct packed {
      logic [7:0]        short_limit;
      logic [7:0]        long_low;
      logic [7:0]        long_high;
      logic [ADDR_W-1:0] own_address;
      logic [DATA_W-1:0] own_data;
   } cfg_type;

   // One result transaction
   typedef struct packed {
      logic              drive_on;
      logic              restart_hold;
      logic              frame_done;
      logic              frame_confirmed;
      logic [ADDR_W-1:0] rx_address;
      logic [FUNC_W-1:0] rx_function;
      logic [DATA_W-1:0] rx_data;
   } rsp_type;

   // Ternary switch value to address: digits 0,1,2 map to 00,11,10, low digit
   // lands in the top bits. Divide by 3 through x*43 >> 7, exact below 128.
   function automatic logic [ADDR_W-1:0] own_address_f(input logic [5:0] sw);
      logic [5:0]        rest;
      logic [12:0]       prod;
      logic [5:0]        quot;
      logic [5:0]        rem6;
      logic [ADDR_W-1:0] acc;
      rest = sw;
      acc  = '0;
      for (int i = 0; i < 4; i++) begin
         prod = 13'(rest) * 13'd43;
         quot = prod[12:7];
         rem6 = rest - (quot + {quot[4:0], 1'b0});
         acc  = {acc[ADDR_W-3:0], 2'b00};
         if (rem6 == 6'd1) begin
            acc[1:0] = 2'b11;
         end else if (rem6 == 6'd2) begin
            acc[1:0] = 2'b10;
         end
         rest = quot;
      end
      return acc;
   endfunction

   function automatic logic [DATA_W-1:0] own_data_f(input logic [2:0] sw);
      return {sw[2], sw[2], sw[1], sw[1], sw[0], sw[0], 2'b11};
   endfunction

endpackage

`default_nettype wire

/* rtl/rafd_csr.sv */
// ---------------------------------------------------------------------------
// rafd_csr
// Configuration registers and derived own address / own data word.
// ---------------------------------------------------------------------------
`default_nettype none

module rafd_csr
   import rafd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  wr_en,
   input  wire logic [CSR_IDX_W-1:0]  wr_index,
   input  wire logic [CSR_DATA_W-1:0] wr_data,
   output cfg_type                    cfg
);

   logic [7:0] short_limit_ff, short_limit_in;
   logic [7:0] long_low_ff,    long_low_in;
   logic [7:0] long_high_ff,   long_high_in;
   logic [5:0] sw_addr_ff,     sw_addr_in;
   logic [2:0] sw_data_ff,     sw_data_in;

   always_comb begin
      short_limit_in = short_limit_ff;
      long_low_in    = long_low_ff;
      long_high_in   = long_high_ff;
      sw_addr_in     = sw_addr_ff;
      sw_data_in     = sw_data_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_SHORT_LIMIT:    short_limit_in = wr_data;
            CSR_LONG_LOW:       long_low_in    = wr_data;
            CSR_LONG_HIGH:      long_high_in   = wr_data;
            CSR_SWITCH_ADDRESS: sw_addr_in     = wr_data[5:0];
            CSR_SWITCH_DATA:    sw_data_in     = wr_data[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_limit_ff <= SHORT_LIMIT_RST;
         long_low_ff    <= LONG_LOW_RST;
         long_high_ff   <= LONG_HIGH_RST;
         sw_addr_ff     <= '0;
         sw_data_ff     <= '0;
      end else begin
         short_limit_ff <= short_limit_in;
         long_low_ff    <= long_low_in;
         long_high_ff   <= long_high_in;
         sw_addr_ff     <= sw_addr_in;
         sw_data_ff     <= sw_data_in;
      end
   end

   assign cfg.short_limit = short_limit_ff;
   assign cfg.long_low    = long_low_ff;
   assign cfg.long_high   = long_high_ff;
   assign cfg.own_address = own_address_f(sw_addr_ff);
   assign cfg.own_data    = own_data_f(sw_data_ff);

endmodule

`default_nettype wire

/* rtl/rafd_engine.sv */
// ---------------------------------------------------------------------------
// rafd_engine
// Input register, bit decode, frame assembly, confirmation and output level.
// ---------------------------------------------------------------------------
`default_nettype none

module rafd_engine
   import rafd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic       in_valid,
   output logic            in_stall,
   input  wire logic [1:0] in_mode,
   input  wire logic       in_line_low,
   input  wire logic [7:0] in_elapsed,
   output logic            push,
   input  wire logic       push_ok,
   output rsp_type         push_rsp
);

   logic                  in_valid_ff, in_valid_in;
   mode_type              mode_ff;
   logic                  line_low_ff;
   logic [7:0]            elapsed_ff;
   logic [COUNT_W-1:0]    bit_count_ff, bit_count_in;
   logic [FRAME_BITS-1:0] shift_ff, shift_in;
   logic [FRAME_BITS-1:0] prev_ff, prev_in;
   logic                  active_ff, active_in;

   logic                  take;
   logic                  have_bit;
   logic                  bit_val;
   logic [FRAME_BITS-1:0] shifted;
   logic [COUNT_W-1:0]    count_inc;
   logic                  complete;
   logic                  confirmed;
   logic                  own_match;

   assign take     = in_valid && !in_stall;
   assign push     = in_valid_ff && push_ok;
   assign in_stall = in_valid_ff && !push_ok;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take) begin
         in_valid_in = 1'b1;
      end else if (push) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         mode_ff     <= mode_type'(in_mode);
         line_low_ff <= in_line_low;
         elapsed_ff  <= in_elapsed;
      end
   end

   // Bit windows
   always_comb begin
      have_bit = 1'b0;
      bit_val  = 1'b0;
      if (elapsed_ff < cfg.short_limit) begin
         have_bit = 1'b1;
      end else if ((elapsed_ff > cfg.long_low) && (elapsed_ff < cfg.long_high)) begin
         have_bit = 1'b1;
         bit_val  = 1'b1;
      end
   end

   assign shifted   = {shift_ff[FRAME_BITS-2:0], bit_val};
   assign count_inc = bit_count_ff + COUNT_W'(1);
   assign complete  = (mode_ff == MODE_EDGE) && line_low_ff && have_bit
                      && (count_inc >= COUNT_W'(FRAME_BITS));
   assign confirmed = complete && (shifted == prev_ff);
   assign own_match = (shifted[FRAME_BITS-1 -: ADDR_W] == cfg.own_address)
                      && (shifted[DATA_W +: FUNC_W] == '0);

   always_comb begin
      bit_count_in = bit_count_ff;
      shift_in     = shift_ff;
      prev_in      = prev_ff;
      active_in    = active_ff;
      push_rsp     = '0;
      unique case (mode_ff)
         MODE_EDGE: begin
            if (line_low_ff && have_bit) begin
               if (complete) begin
                  bit_count_in = '0;
                  shift_in     = '0;
                  if (!confirmed) begin
                     prev_in = shifted;
                  end else if (own_match) begin
                     if (shifted[DATA_W-1:0] == cfg.own_data) begin
                        active_in             = 1'b1;
                        push_rsp.restart_hold = 1'b1;
                     end else if (shifted[1:0] == 2'b00) begin
                        active_in = 1'b0;
                     end
                  end
               end else begin
                  bit_count_in = count_inc;
                  shift_in     = shifted;
               end
            end
         end
         MODE_GAP: begin
            bit_count_in = '0;
            shift_in     = '0;
         end
         MODE_HOLD: begin
            active_in = 1'b0;
         end
         MODE_SPARE: ;
         default: ;
      endcase
      push_rsp.drive_on        = active_in;
      push_rsp.frame_done      = complete;
      push_rsp.frame_confirmed = confirmed;
      if (complete) begin
         push_rsp.rx_address  = shifted[FRAME_BITS-1 -: ADDR_W];
         push_rsp.rx_function = shifted[DATA_W +: FUNC_W];
         push_rsp.rx_data     = shifted[DATA_W-1:0];
      end
   end

   // Decoder state advances only when the transaction moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_count_ff <= '0;
         shift_ff     <= '0;
         prev_ff      <= '0;
         active_ff    <= 1'b0;
      end else if (push) begin
         bit_count_ff <= bit_count_in;
         shift_ff     <= shift_in;
         prev_ff      <= prev_in;
         active_ff    <= active_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/rafd_out_buf.sv */
// ---------------------------------------------------------------------------
// rafd_out_buf
// Two-entry result buffer between the frame engine and the result channel.
// ---------------------------------------------------------------------------
`default_nettype none

module rafd_out_buf
   import rafd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire rsp_type push_rsp,
   output logic         push_ok,
   output logic         out_valid,
   input  wire logic    out_stall,
   output rsp_type      out_rsp
);

   rsp_type    slot_ff [2];
   logic       head_ff, head_in;
   logic       tail_ff, tail_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign out_valid = (count_ff != 2'd0);
   assign push_ok   = (count_ff != 2'd2);
   assign pop       = out_valid && !out_stall;
   assign out_rsp   = slot_ff[head_ff];

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = ~tail_ff;
      end
      if (pop) begin
         head_in = ~head_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 1'b0;
         tail_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[tail_ff] <= push_rsp;
      end
   end

endmodule

`default_nettype wire

/* rtl/rail_accessory_frame_decoder.sv */
// ---------------------------------------------------------------------------
// rail_accessory_frame_decoder
// Accessory decoder for a model railway track signal: line events become
// bits, bits become 18-bit frames, repeated frames switch the output.
// ---------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Payload
//  req_     in         req_valid/req_stall  mode, line_low, elapsed
//  rsp_     out        rsp_valid/rsp_stall  drive_on, restart_hold, frame_done,
//                                           frame_confirmed, rx_address,
//                                           rx_function, rx_data
//  csr_     in         csr_valid/csr_ready  csr_index, csr_data
//
//  Every request transaction yields exactly one response transaction.
//  Requests pass through the input register and then the result buffer.
//  One transaction per cycle is sustained while rsp_stall is low; the decode
//  path from the input register to the result buffer is combinational.
//  reset is synchronous, active high; it clears the frame state, the output
//  level and restores the register defaults.
//  A two-entry result buffer keeps requests flowing while a response waits;
//  req_stall rises only when that buffer is full and the input register holds.
//  csr_ready is always high; write registers only while the block is idle.
// ---------------------------------------------------------------------------
`default_nettype none

module rail_accessory_frame_decoder
   import rafd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [1:0]            req_mode,
   input  wire logic                  req_line_low,
   input  wire logic [7:0]            req_elapsed,

   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_drive_on,
   output logic                       rsp_restart_hold,
   output logic                       rsp_frame_done,
   output logic                       rsp_frame_confirmed,
   output logic [ADDR_W-1:0]          rsp_rx_address,
   output logic [FUNC_W-1:0]          rsp_rx_function,
   output logic [DATA_W-1:0]          rsp_rx_data,

   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type cfg;
   rsp_type push_rsp;
   rsp_type out_rsp;
   logic    push;
   logic    push_ok;

   // Register writes are always taken
   assign csr_ready = 1'b1;

   rafd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   // Decode the event and advance frame state when its result can be stored
   rafd_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .in_valid    (req_valid),
      .in_stall    (req_stall),
      .in_mode     (req_mode),
      .in_line_low (req_line_low),
      .in_elapsed  (req_elapsed),
      .push        (push),
      .push_ok     (push_ok),
      .push_rsp    (push_rsp)
   );

   // Hold results until the response side takes them
   rafd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_rsp  (push_rsp),
      .push_ok   (push_ok),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_rsp   (out_rsp)
   );

   assign rsp_drive_on        = out_rsp.drive_on;
   assign rsp_restart_hold    = out_rsp.restart_hold;
   assign rsp_frame_done      = out_rsp.frame_done;
   assign rsp_frame_confirmed = out_rsp.frame_confirmed;
   assign rsp_rx_address      = out_rsp.rx_address;
   assign rsp_rx_function     = out_rsp.rx_function;
   assign rsp_rx_data         = out_rsp.rx_data;

endmodule

`default_nettype wire
